[hw/rtl/dai_pkg.sv]
// ----------------------------------------------------------------------------
// dai_pkg
// Shared types, widths and codes for the downscaled accumulate image block.
// ----------------------------------------------------------------------------
package dai_pkg;

  localparam int POS_W       = 24;
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int CH_W        = 2;
  localparam int COORD_OUT_W = 7;
  localparam int CFG_W       = 23;
  localparam int CFG_IDX_W   = 2;
  localparam int VDIM_W      = 23;
  localparam int PPP_W       = 16;

  localparam int DIVD_W    = 24;
  localparam int DIVS_W    = 23;
  localparam int DIV_CNT_W = 5;

  localparam int DEF_SIDE     = 128;
  localparam int DEF_CHANNELS = 4;

  localparam logic [VDIM_W-1:0] VWIDTH_RST  = VDIM_W'(128);
  localparam logic [VDIM_W-1:0] VHEIGHT_RST = VDIM_W'(128);
  localparam logic [PPP_W-1:0]  PPP_RST     = PPP_W'(1);

  localparam logic [OP_W-1:0] OP_SET = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD = 2'd1;
  localparam logic [OP_W-1:0] OP_MAX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VWIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VHEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPP     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [CH_W-1:0]         channel;
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;
    logic signed [VAL_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_OUT_W-1:0]  pixel_column;
    logic [COORD_OUT_W-1:0]  pixel_row;
    logic signed [VAL_W-1:0] new_contents;
    logic                    contents_defined;
    logic                    saturated;
  } out_item_t;

endpackage

[hw/rtl/dai_divider.sv]
// ----------------------------------------------------------------------------
// dai_divider
// Restoring divider, one quotient bit per cycle, shared by modulo and divide.
// ----------------------------------------------------------------------------
module dai_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dai_pkg::DIVD_W-1:0]   dividend,
  input  logic [dai_pkg::DIVS_W-1:0]   divisor,
  output logic                         done,
  output logic [dai_pkg::DIVD_W-1:0]   quotient,
  output logic [dai_pkg::DIVS_W-1:0]   remainder
);
  import dai_pkg::*;

  localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(DIVD_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    dvs_r;

  logic [DIVS_W:0]      shifted;
  logic [DIVS_W+1:0]    diff;
  logic                 fits;

  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = ~diff[DIVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == STEP_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], fits};
      rem_r <= fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/dai_coord.sv]
// ----------------------------------------------------------------------------
// dai_coord
// One coordinate lane: wraps a signed position modulo the virtual size, then
// divides by the downscale factor and clamps to the stored image side.
// ----------------------------------------------------------------------------
module dai_coord #(
  parameter int SIDE = dai_pkg::DEF_SIDE
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [dai_pkg::POS_W-1:0]      pos,
  input  logic [dai_pkg::VDIM_W-1:0]            modulus,
  input  logic [dai_pkg::PPP_W-1:0]             factor,
  output logic                                  done,
  output logic [((SIDE > 1) ? $clog2(SIDE) : 1)-1:0] pixel
);
  import dai_pkg::*;

  localparam int COL_W = (SIDE > 1) ? $clog2(SIDE) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]        state_r;
  logic              done_r;
  logic              neg_r;
  logic [VDIM_W-1:0] mod_r;
  logic [PPP_W-1:0]  fac_r;
  logic [COL_W-1:0]  pixel_r;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;
  logic [DIVS_W-1:0] div_rem;

  logic [VDIM_W-1:0] mod_eff;
  logic [POS_W-1:0]  mag;
  logic [VDIM_W-1:0] wrapped;

  always_comb begin
    mod_eff = (modulus == '0) ? VDIM_W'(1) : modulus;
    mag     = pos[POS_W-1] ? (~pos + 1'b1) : pos;
    wrapped = (neg_r && div_rem != '0) ? (mod_r - div_rem) : div_rem;

    div_start    = 1'b0;
    div_dividend = DIVD_W'(mag);
    div_divisor  = DIVS_W'(mod_eff);
    if (state_r == ST_IDLE && start) begin
      div_start = 1'b1;
    end else if (state_r == ST_MOD && div_done) begin
      div_start    = 1'b1;
      div_dividend = DIVD_W'(wrapped);
      div_divisor  = DIVS_W'(fac_r);
    end
  end

  dai_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == ST_DIV) && div_done;
      unique case (state_r)
        ST_IDLE: begin
          if (start) state_r <= ST_MOD;
        end
        ST_MOD: begin
          if (div_done) state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      neg_r <= pos[POS_W-1];
      mod_r <= mod_eff;
      fac_r <= (factor == '0) ? PPP_W'(1) : factor;
    end
    if (state_r == ST_DIV && div_done) begin
      pixel_r <= (div_quo > DIVD_W'(SIDE - 1)) ? COL_W'(SIDE - 1) : div_quo[COL_W-1:0];
    end
  end

  assign done  = done_r;
  assign pixel = pixel_r;

endmodule

[hw/rtl/dai_store.sv]
// ----------------------------------------------------------------------------
// dai_store
// Pixel word memory and defined-bit memory; the defined bits are swept to
// zero after reset.
// ----------------------------------------------------------------------------
module dai_store #(
  parameter int SIDE     = dai_pkg::DEF_SIDE,
  parameter int CHANNELS = dai_pkg::DEF_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [((CHANNELS * SIDE * SIDE > 1) ? $clog2(CHANNELS * SIDE * SIDE) : 1)-1:0] rd_addr,
  output logic [dai_pkg::VAL_W-1:0] rd_data,
  output logic                     rd_def,
  input  logic                     wr_en,
  input  logic [((CHANNELS * SIDE * SIDE > 1) ? $clog2(CHANNELS * SIDE * SIDE) : 1)-1:0] wr_addr,
  input  logic [dai_pkg::VAL_W-1:0] wr_data,
  output logic                     clearing
);
  import dai_pkg::*;

  localparam int DEPTH  = CHANNELS * SIDE * SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] data_mem [DEPTH];
  logic             def_mem  [DEPTH];

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [VAL_W-1:0]  rd_data_r;
  logic              rd_def_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      def_mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      def_mem[wr_addr] <= 1'b1;
    end
    if (rd_en) rd_def_r <= def_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) data_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= data_mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign rd_def   = rd_def_r;
  assign clearing = clearing_r;

endmodule

[hw/rtl/downscaled_accumulate_image.sv]
// ----------------------------------------------------------------------------
// downscaled_accumulate_image
// Set, add or max of Q16.16 samples into a downscaled multi-channel image.
// ----------------------------------------------------------------------------
// After reset the block sweeps the defined bits of all CHANNELS*SIDE*SIDE
// pixels and holds in_stall high during that pass; configuration writes are
// taken throughout. A new transaction is accepted only once the previous one
// has left its update state. x and y each run through their own restoring
// divider, first for the wrap modulo and then for the downscale divide (24
// quotient steps each), followed by a pixel register, an address register, a
// memory read and an update state. The result sits in an output register, so
// a new transaction can be accepted while the previous result is still
// stalled; the update waits only if that result is still stalled when the
// next one is ready.
module downscaled_accumulate_image #(
  parameter int SIDE     = dai_pkg::DEF_SIDE,
  parameter int CHANNELS = dai_pkg::DEF_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dai_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dai_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dai_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dai_pkg::CFG_W-1:0]         cfg_data
);
  import dai_pkg::*;

  localparam int COL_W  = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int DEPTH  = CHANNELS * SIDE * SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COORD  = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [VDIM_W-1:0] vwidth_r;
  logic [VDIM_W-1:0] vheight_r;
  logic [PPP_W-1:0]  ppp_r;

  logic [1:0]        state_r;
  logic [OP_W-1:0]   op_r;
  logic [CH_W-1:0]   ch_r;
  logic [VAL_W-1:0]  val_r;
  logic              xd_r;
  logic              yd_r;
  logic [ADDR_W-1:0] addr_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              accept;
  logic              clearing;
  logic              x_done;
  logic              y_done;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic              coords_ready;
  logic [ADDR_W-1:0] addr_nxt;
  logic [CH_W-1:0]   ch_clamped;

  logic [VAL_W-1:0]  rd_data;
  logic              rd_def;
  logic              rd_en;
  logic              wr_en;
  logic              out_free;

  logic [VAL_W:0]    sum;
  logic              sat_hi;
  logic              sat_lo;
  logic              greater;
  logic [VAL_W-1:0]  new_val;
  logic              new_def;
  logic              new_sat;
  logic              do_write;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = clearing || (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vwidth_r  <= VWIDTH_RST;
      vheight_r <= VHEIGHT_RST;
      ppp_r     <= PPP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VWIDTH:  vwidth_r  <= cfg_data[VDIM_W-1:0];
        REG_VHEIGHT: vheight_r <= cfg_data[VDIM_W-1:0];
        REG_PPP:     ppp_r     <= cfg_data[PPP_W-1:0];
        default: ;
      endcase
    end
  end

  dai_coord #(.SIDE(SIDE)) u_coord_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .pos     (in_data.x_position),
    .modulus (vwidth_r),
    .factor  (ppp_r),
    .done    (x_done),
    .pixel   (col)
  );

  dai_coord #(.SIDE(SIDE)) u_coord_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .pos     (in_data.y_position),
    .modulus (vheight_r),
    .factor  (ppp_r),
    .done    (y_done),
    .pixel   (row)
  );

  dai_store #(.SIDE(SIDE), .CHANNELS(CHANNELS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (addr_r),
    .rd_data  (rd_data),
    .rd_def   (rd_def),
    .wr_en    (wr_en),
    .wr_addr  (addr_r),
    .wr_data  (new_val),
    .clearing (clearing)
  );

  always_comb begin
    ch_clamped   = (in_data.channel > CH_W'(CHANNELS - 1)) ? CH_W'(CHANNELS - 1)
                                                           : in_data.channel;
    coords_ready = (xd_r || x_done) && (yd_r || y_done);
    addr_nxt     = ADDR_W'(ch_r) * ADDR_W'(SIDE * SIDE) + ADDR_W'(row) * ADDR_W'(SIDE)
                 + ADDR_W'(col);
    rd_en        = (state_r == ST_READ);
  end

  always_comb begin
    sum     = {rd_data[VAL_W-1], rd_data} + {val_r[VAL_W-1], val_r};
    sat_hi  = !sum[VAL_W] && sum[VAL_W-1];
    sat_lo  = sum[VAL_W] && !sum[VAL_W-1];
    greater = $signed(val_r) > $signed(rd_data);

    new_val  = rd_data;
    new_def  = rd_def;
    new_sat  = 1'b0;
    do_write = 1'b0;
    unique case (op_r)
      OP_SET: begin
        new_val  = val_r;
        new_def  = 1'b1;
        do_write = 1'b1;
      end
      OP_ADD: begin
        new_def  = 1'b1;
        do_write = 1'b1;
        if (!rd_def) begin
          new_val = val_r;
        end else if (sat_hi) begin
          new_val = {1'b0, {(VAL_W-1){1'b1}}};
          new_sat = 1'b1;
        end else if (sat_lo) begin
          new_val = {1'b1, {(VAL_W-1){1'b0}}};
          new_sat = 1'b1;
        end else begin
          new_val = sum[VAL_W-1:0];
        end
      end
      OP_MAX: begin
        if (!rd_def || greater) begin
          new_val  = val_r;
          new_def  = 1'b1;
          do_write = 1'b1;
        end
      end
      default: ;
    endcase

    wr_en = (state_r == ST_UPDATE) && out_free && do_write;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      xd_r        <= 1'b0;
      yd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPDATE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) state_r <= ST_COORD;
        end
        ST_COORD: begin
          if (coords_ready) begin
            xd_r    <= 1'b0;
            yd_r    <= 1'b0;
            state_r <= ST_READ;
          end else begin
            if (x_done) xd_r <= 1'b1;
            if (y_done) yd_r <= 1'b1;
          end
        end
        ST_READ: state_r <= ST_UPDATE;
        ST_UPDATE: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.operation;
      ch_r  <= ch_clamped;
      val_r <= in_data.sample_value;
    end
    if (state_r == ST_COORD && coords_ready) addr_r <= addr_nxt;
    if (state_r == ST_UPDATE && out_free) begin
      out_data_r.pixel_column     <= COORD_OUT_W'(col);
      out_data_r.pixel_row        <= COORD_OUT_W'(row);
      out_data_r.new_contents     <= new_def ? new_val : '0;
      out_data_r.contents_defined <= new_def;
      out_data_r.saturated        <= new_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/downscaled_accumulate_image_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_update_checker
// Watches the config, input and result channels of the downscaled accumulate
// image block, keeps its own copy of the registers and the pixel store, and
// compares every result transaction field by field with the predicted one.
// ----------------------------------------------------------------------------
module pixel_update_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  dai_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  dai_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dai_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dai_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pixels_pending
);
  import dai_pkg::*;

  localparam int SIDE     = DEF_SIDE;
  localparam int CHANNELS = DEF_CHANNELS;
  localparam int PIXELS   = CHANNELS * SIDE * SIDE;
  localparam int MAX_PRINTED = 100;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh80000000;

  logic [VDIM_W-1:0]       span_x;
  logic [VDIM_W-1:0]       span_y;
  logic [PPP_W-1:0]        scale;
  logic signed [VAL_W-1:0] pixel_value [PIXELS];
  bit                      pixel_set   [PIXELS];
  out_item_t               expected_pixels [$];

  initial mismatches = 0;

  task automatic report(input string what);
    if (mismatches < MAX_PRINTED) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [COORD_OUT_W-1:0] wrap_scale(logic signed [POS_W-1:0] pos,
                                                        logic [VDIM_W-1:0] span,
                                                        logic [PPP_W-1:0] ppp);
    longint m;
    longint r;
    longint d;
    longint p;
    m = (span == 0) ? 1 : longint'(span);
    r = longint'(pos) % m;
    if (r < 0) r += m;
    d = (ppp == 0) ? 1 : longint'(ppp);
    p = r / d;
    if (p > SIDE - 1) p = SIDE - 1;
    return COORD_OUT_W'(p);
  endfunction

  function automatic out_item_t apply_pixel_op(in_item_t t);
    out_item_t               res;
    logic [CH_W-1:0]         ch;
    logic [COORD_OUT_W-1:0]  col;
    logic [COORD_OUT_W-1:0]  row;
    int                      idx;
    longint                  total;
    logic signed [VAL_W-1:0] v;
    ch = t.channel;
    if (ch > CHANNELS - 1) ch = CH_W'(CHANNELS - 1);
    v = t.sample_value;
    col = wrap_scale(t.x_position, span_x, scale);
    row = wrap_scale(t.y_position, span_y, scale);
    idx = (int'(ch) * SIDE + int'(row)) * SIDE + int'(col);
    res = '0;
    case (t.operation)
      OP_SET: begin
        pixel_value[idx] = v;
        pixel_set[idx] = 1'b1;
      end
      OP_ADD: begin
        if (pixel_set[idx]) begin
          total = longint'(pixel_value[idx]) + longint'(v);
          if (total > longint'(Q_MAX)) begin
            total = longint'(Q_MAX);
            res.saturated = 1'b1;
          end else if (total < longint'(Q_MIN)) begin
            total = longint'(Q_MIN);
            res.saturated = 1'b1;
          end
          pixel_value[idx] = VAL_W'(total);
        end else begin
          pixel_value[idx] = v;
          pixel_set[idx] = 1'b1;
        end
      end
      OP_MAX: begin
        if (!pixel_set[idx] || v > pixel_value[idx]) begin
          pixel_value[idx] = v;
          pixel_set[idx] = 1'b1;
        end
      end
      default: ;  // reserved op leaves the pixel alone
    endcase
    res.pixel_column     = col;
    res.pixel_row        = row;
    res.contents_defined = pixel_set[idx];
    res.new_contents     = pixel_set[idx] ? pixel_value[idx] : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      span_x = VWIDTH_RST;
      span_y = VHEIGHT_RST;
      scale  = PPP_RST;
      foreach (pixel_set[i]) pixel_set[i] = 1'b0;
      expected_pixels.delete();
      pixels_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VWIDTH:  span_x = cfg_data;
          REG_VHEIGHT: span_y = cfg_data;
          REG_PPP:     scale = cfg_data[PPP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_pixels.push_back(apply_pixel_op(in_data));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report($sformatf("result with no transaction pending: %p", out_data));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_column !== want.pixel_column)
            report($sformatf("pixel_column got %0d expected %0d",
                             out_data.pixel_column, want.pixel_column));
          if (out_data.pixel_row !== want.pixel_row)
            report($sformatf("pixel_row got %0d expected %0d",
                             out_data.pixel_row, want.pixel_row));
          if (out_data.new_contents !== want.new_contents)
            report($sformatf("new_contents at (%0d,%0d) got %h expected %h",
                             want.pixel_column, want.pixel_row,
                             out_data.new_contents, want.new_contents));
          if (out_data.contents_defined !== want.contents_defined)
            report($sformatf("contents_defined at (%0d,%0d) got %b expected %b",
                             want.pixel_column, want.pixel_row,
                             out_data.contents_defined, want.contents_defined));
          if (out_data.saturated !== want.saturated)
            report($sformatf("saturated at (%0d,%0d) got %b expected %b",
                             want.pixel_column, want.pixel_row,
                             out_data.saturated, want.saturated));
        end
      end
      pixels_pending <= expected_pixels.size();
    end
  end

endmodule

[tb/downscaled_accumulate_image_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downscaled_accumulate_image_tb
// Drives set, add, max and reserved transactions into the downscaled accumulate
// image block under a series of register settings, with bursty input and a
// varying result stall; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module downscaled_accumulate_image_tb;
  import dai_pkg::*;

  localparam logic [OP_W-1:0]      OP_RESERVED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;
  localparam int                   WATCHDOG_LIMIT = 200000;
  localparam int                   DRAIN_CYCLES   = 64;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatches;
  int pixels_pending;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  logic [VDIM_W-1:0] span_x = VWIDTH_RST;
  logic [VDIM_W-1:0] span_y = VHEIGHT_RST;
  logic [PPP_W-1:0]  scale = PPP_RST;

  in_item_t directed_items [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  downscaled_accumulate_image dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_update_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending)
  );

  // result-side stall: free, light, heavy, or long alternating holds
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          out_stall <= ~out_stall;
          hold_left <= $urandom_range(1, 60);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT - 1) begin
      $display("downscaled_accumulate_image test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                         int x, int y, logic signed [VAL_W-1:0] v);
    in_item_t t;
    t.operation    = op;
    t.channel      = ch;
    t.x_position   = POS_W'(x);
    t.y_position   = POS_W'(y);
    t.sample_value = v;
    return t;
  endfunction

  // mostly near the origin or a few spans away, so pixels get hit repeatedly
  function automatic int rand_pos(int span, int ppp);
    int k;
    int unit;
    int wrap;
    int near;
    k = $urandom_range(0, 9);
    unit = (ppp == 0) ? 1 : ppp;
    wrap = (span == 0) ? 1 : span;
    near = int'($urandom_range(0, 16 * unit)) - 8 * unit;
    if (k < 7) return near + (int'($urandom_range(0, 4)) - 2) * wrap;
    if (k < 9) return int'($urandom);
    case ($urandom_range(0, 3))
      0: return -8388608;
      1: return 8388607;
      2: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return (int'($urandom_range(0, 200)) - 100) <<< 16;
      7: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      8: return 32'sh7FFF0000 + $urandom_range(0, 65535);
      default: return 32'sh80000000 + $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_SET;
    else if (r < 62) op = OP_ADD;
    else if (r < 94) op = OP_MAX;
    else op = OP_RESERVED;
    return make_item(op, CH_W'($urandom_range(0, 3)), rand_pos(int'(span_x), int'(scale)),
                     rand_pos(int'(span_y), int'(scale)), rand_value());
  endfunction

  task automatic send(in_item_t t);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] p,
                           int count);
    cfg_write(REG_VWIDTH, w);
    cfg_write(REG_VHEIGHT, h);
    cfg_write(REG_PPP, p);
    span_x = w;
    span_y = h;
    scale = p[PPP_W-1:0];
    repeat (count) send(rand_item());
    drain();
  endtask

  initial begin
    directed_items.push_back(make_item(OP_SET, 0, 0, 0, 32'sh7FFFFFFF));
    directed_items.push_back(make_item(OP_ADD, 0, 0, 0, 1));
    directed_items.push_back(make_item(OP_SET, 1, 1, 1, 32'sh80000000));
    directed_items.push_back(make_item(OP_ADD, 1, 1, 1, -1));
    directed_items.push_back(make_item(OP_ADD, 1, 1, 1, 32'sh7FFFFFFF));
    directed_items.push_back(make_item(OP_ADD, 2, 5, 5, 32'sh00018000));
    directed_items.push_back(make_item(OP_ADD, 2, 133, -123, 32'shFFFF0000));
    directed_items.push_back(make_item(OP_MAX, 3, 2, 2, 32'sh80000000));
    directed_items.push_back(make_item(OP_MAX, 3, 2, 2, -5));
    directed_items.push_back(make_item(OP_MAX, 3, -126, 130, -10));
    directed_items.push_back(make_item(OP_MAX, 3, 2, 2, 32'sh7FFFFFFF));
    directed_items.push_back(make_item(OP_RESERVED, 3, 2, 2, 0));
    directed_items.push_back(make_item(OP_RESERVED, 0, 9, 9, 12345));
    directed_items.push_back(make_item(OP_SET, 2, -1, -8388608, 0));
    directed_items.push_back(make_item(OP_SET, 1, 8388607, -128, -1));
    directed_items.push_back(make_item(OP_ADD, 0, -129, 255, 32'sh00010000));
    directed_items.push_back(make_item(OP_MAX, 0, -129, 255, 32'sh00010000));
    directed_items.push_back(make_item(OP_SET, 3, 64, 64, 32'sh55555555));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_items[i]) send(directed_items[i]);
    repeat (300) send(rand_item());
    drain();

    run_phase(0, 0, 0, 100);
    run_phase(8388607, 1, 65535, 200);
    cfg_write(REG_UNUSED, CFG_W'($urandom));
    run_phase(3, 200, 23'h7F0002, 250);
    run_phase(1000, 777, 8, 250);
    run_phase(256, 130, 1, 250);
    run_phase(CFG_W'($urandom_range(1, 1024)), CFG_W'($urandom_range(1, 1024)),
              CFG_W'($urandom_range(1, 8)), 250);
    run_phase(CFG_W'($urandom_range(1, 8388607)), CFG_W'($urandom_range(1, 8388607)),
              CFG_W'($urandom_range(1, 65535)), 150);
    run_phase(VWIDTH_RST, VHEIGHT_RST, CFG_W'(PPP_RST), 200);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("downscaled_accumulate_image test passed");
    end else begin
      $display("downscaled_accumulate_image test failed");
    end
    $finish;
  end

endmodule
